FILE: design/tad_pkg.sv
package tad_pkg;

   localparam logic [7:0] APDU_START = 8'h68;
   localparam logic [1:0] TYPE_MASK  = 2'h3;
   localparam logic [1:0] CTL_I      = 2'h0;
   localparam logic [1:0] CTL_I_ALT  = 2'h2;
   localparam logic [1:0] CTL_S      = 2'h1;
   localparam logic [7:0] APCI_CTL_LEN = 8'd4;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [1:0] FRAME_I = 2'd0;
   localparam logic [1:0] FRAME_S = 2'd1;
   localparam logic [1:0] FRAME_U = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_CTL0 = 3'd2,
      PH_CTL1 = 3'd3,
      PH_CTL2 = 3'd4,
      PH_CTL3 = 3'd5,
      PH_DATA = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  frame_type;
      logic [14:0] send_seq;
      logic [14:0] recv_seq;
      logic [5:0]  unnumbered_func;
      logic [7:0]  payload_len;
      logic [7:0]  payload_byte;
      logic        frame_last;
      logic        status;
   } rsp_type;

endpackage

FILE: design/tad_hdr_decode.sv
module tad_hdr_decode
   import tad_pkg::*;
(
   input  logic [23:0] ctl_bytes,
   input  logic [7:0]  ctl3_byte,
   input  logic [7:0]  length_field,
   input  logic        buffer_end,
   output rsp_type     hdr,
   output logic        hdr_more
);

   logic [7:0]  ctl0;
   logic [15:0] lo_word;
   logic [15:0] hi_word;

   assign ctl0    = ctl_bytes[7:0];
   assign lo_word = ctl_bytes[15:0];
   assign hi_word = {ctl3_byte, ctl_bytes[23:16]};

   always_comb begin
      hdr            = '0;
      hdr.kind       = KIND_HEADER;
      hdr.frame_last = 1'b1;
      hdr_more       = 1'b0;
      case (ctl0[1:0] & TYPE_MASK) inside
         CTL_I, CTL_I_ALT: begin
            hdr.frame_type = FRAME_I;
            hdr.send_seq   = lo_word[15:1];
            hdr.recv_seq   = hi_word[15:1];
            if ((length_field <= APCI_CTL_LEN) || buffer_end) begin
               hdr.status = 1'b1;
            end else begin
               hdr.payload_len = length_field - APCI_CTL_LEN;
               hdr.frame_last  = 1'b0;
               hdr_more        = 1'b1;
            end
         end
         CTL_S: begin
            hdr.frame_type = FRAME_S;
            hdr.recv_seq   = hi_word[15:1];
         end
         default: begin
            hdr.frame_type      = FRAME_U;
            hdr.unnumbered_func = ctl0[7:2];
         end
      endcase
   end

endmodule

FILE: design/telecontrol_apdu_deframer.sv
// This block deframes APCI headers from a byte stream and takes one byte per clock cycle while req_stall is low.
// Every transfer passes through an input register, the parse logic and a result register,
// so a byte that is accepted is held in the input register and parsed, and its result, if
// any, is written into the result register, from which it can then transfer. A header
// result follows the fourth control byte, and information frames then yield one result per
// payload byte, with the last one marked. While a result is held back the input register
// still takes one more byte, and after that req_stall stays high until the result transfers.
// The sustained rate is one byte per cycle as long as the result side does not stall.
module telecontrol_apdu_deframer
   import tad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  length_ff, length_in;
   logic [23:0] ctl_ff, ctl_in;
   logic [7:0]  left_ff, left_in;

   logic        out_free;
   logic        step;
   logic        emit;
   rsp_type     res;
   rsp_type     hdr;
   logic        hdr_more;
   logic [7:0]  b;
   logic        last_in_buf;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign step        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign b           = in_data_ff.data_byte;
   assign last_in_buf = in_data_ff.buffer_end;

   tad_hdr_decode u_hdr (
      .ctl_bytes    (ctl_ff),
      .ctl3_byte    (b),
      .length_field (length_ff),
      .buffer_end   (last_in_buf),
      .hdr          (hdr),
      .hdr_more     (hdr_more)
   );

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      ctl_in    = ctl_ff;
      left_in   = left_ff;
      case (phase_ff)
         PH_HUNT: begin
            if ((b == APDU_START) && !last_in_buf) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            length_in = b;
            ctl_in    = '0;
            phase_in  = last_in_buf ? PH_HUNT : PH_CTL0;
         end
         PH_CTL0: begin
            ctl_in[7:0] = b;
            phase_in    = last_in_buf ? PH_HUNT : PH_CTL1;
         end
         PH_CTL1: begin
            ctl_in[15:8] = b;
            phase_in     = last_in_buf ? PH_HUNT : PH_CTL2;
         end
         PH_CTL2: begin
            ctl_in[23:16] = b;
            phase_in      = last_in_buf ? PH_HUNT : PH_CTL3;
         end
         PH_CTL3: begin
            if (hdr_more) begin
               left_in  = hdr.payload_len;
               phase_in = PH_DATA;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_DATA: begin
            if ((left_ff <= 8'd1) || last_in_buf) begin
               left_in  = '0;
               phase_in = PH_HUNT;
            end else begin
               left_in = left_ff - 8'd1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_comb begin
      emit       = 1'b0;
      res        = '0;
      res.kind   = KIND_STATUS;
      res.status = 1'b1;
      res.frame_last = 1'b1;
      case (phase_ff)
         PH_HUNT: begin
            emit = (b == APDU_START) && last_in_buf;
         end
         PH_LEN, PH_CTL0, PH_CTL1, PH_CTL2: begin
            emit = last_in_buf;
         end
         PH_CTL3: begin
            emit = 1'b1;
            res  = hdr;
         end
         PH_DATA: begin
            emit = 1'b1;
            if ((left_ff <= 8'd1) || !last_in_buf) begin
               res              = '0;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = b;
               res.frame_last   = (left_ff <= 8'd1);
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = step ? emit : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT;
         length_ff    <= '0;
         ctl_ff       <= '0;
         left_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff  <= phase_in;
            length_ff <= length_in;
            ctl_ff    <= ctl_in;
            left_ff   <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (step && emit) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/tad_checker.sv
module tad_checker
   import tad_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A result that is held back must stay in place until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind == KIND_HEADER) || (rsp_data.kind == KIND_PAYLOAD) ||
                    (rsp_data.kind == KIND_STATUS))
      else $error("result carries an unknown kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_PAYLOAD) |->
         (rsp_data.frame_type == FRAME_I) && !rsp_data.status)
      else $error("payload result has a frame type or a failing status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.frame_last)
      else $error("failing status on a result that does not close the frame");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_STATUS) |-> rsp_data.status)
      else $error("status-only result reports success");

endmodule

bind telecontrol_apdu_deframer tad_checker u_tad_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
